@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for clocked properties with an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, !(prop), msg)

`endif

@@ hw/rtl/sha1_pkg.sv @@
package sha1_pkg;

  typedef logic [31:0] word_t;

  localparam int NUM_WORDS = 16;
  localparam int NUM_H     = 5;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [6:0] END_CH     = 7'd20;
  localparam logic [6:0] END_PAR1   = 7'd40;
  localparam logic [6:0] END_MAJ    = 7'd60;

  localparam word_t K_CH   = 32'h5a827999;
  localparam word_t K_PAR1 = 32'h6ed9eba1;
  localparam word_t K_MAJ  = 32'h8f1bbcdc;
  localparam word_t K_PAR2 = 32'hca62c1d6;

  localparam word_t PAD_MARK = 32'h8000_0000;

  localparam word_t INIT_H [NUM_H] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [3:0] LEN_HI_POS = 4'd14;
  localparam logic [3:0] LAST_POS   = 4'd15;
  localparam logic [2:0] MAX_BYTES  = 3'd4;

  typedef struct packed {
    logic shift;
    logic feed;
  } sched_ctrl_t;

  function automatic word_t byte_mask(logic [2:0] n);
    word_t m;
    case (n)
      3'd0: m = 32'h0000_0000;
      3'd1: m = 32'hff00_0000;
      3'd2: m = 32'hffff_0000;
      3'd3: m = 32'hffff_ff00;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  function automatic word_t round_f(logic [6:0] t, word_t b, word_t c, word_t d);
    word_t f;
    if (t < END_CH) begin
      f = (b & c) | (~b & d);
    end else if (t < END_PAR1) begin
      f = b ^ c ^ d;
    end else if (t < END_MAJ) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic word_t round_k(logic [6:0] t);
    word_t k;
    if (t < END_CH) begin
      k = K_CH;
    end else if (t < END_PAR1) begin
      k = K_PAR1;
    end else if (t < END_MAJ) begin
      k = K_MAJ;
    end else begin
      k = K_PAR2;
    end
    return k;
  endfunction

endpackage

@@ hw/rtl/sha1_if.sv @@
interface sha1_in_if
  import sha1_pkg::*;
();
  logic       valid;
  logic       ready;
  word_t      data_word;
  logic [2:0] byte_count;
  logic       last;

  modport source(output valid, output data_word, output byte_count, output last,
                 input ready);
  modport sink(input valid, input data_word, input byte_count, input last,
               output ready);
endinterface

interface sha1_out_if
  import sha1_pkg::*;
();
  logic  valid;
  logic  ready;
  word_t digest_h0;
  word_t digest_h1;
  word_t digest_h2;
  word_t digest_h3;
  word_t digest_h4;

  modport source(output valid, output digest_h0, output digest_h1, output digest_h2,
                 output digest_h3, output digest_h4, input ready);
  modport sink(input valid, input digest_h0, input digest_h1, input digest_h2,
               input digest_h3, input digest_h4, output ready);
endinterface

@@ hw/rtl/sha1_cell.sv @@
module sha1_cell
  import sha1_pkg::*;
(
  input  logic  clk_i,
  input  logic  shift_i,
  input  word_t d_i,
  output word_t q_o
);

  word_t word_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      word_q <= d_i;
    end
  end

  assign q_o = word_q;

endmodule

@@ hw/rtl/sha1_sched.sv @@
module sha1_sched
  import sha1_pkg::*;
(
  input  logic        clk_i,
  input  sched_ctrl_t ctrl_i,
  input  word_t       fill_i,
  output word_t       head_o
);

  word_t link [NUM_WORDS + 1];
  word_t mix;

  genvar i;
  for (i = 0; i < NUM_WORDS; i++) begin : g_cell
    sha1_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ctrl_i.shift),
      .d_i     (link[i + 1]),
      .q_o     (link[i])
    );
  end

  // Expand: W[t+16] = rotl1(W[t+13] ^ W[t+8] ^ W[t+2] ^ W[t])
  assign mix = link[13] ^ link[8] ^ link[2] ^ link[0];
  assign link[NUM_WORDS] = ctrl_i.feed ? {mix[30:0], mix[31]} : fill_i;
  assign head_o = link[0];

endmodule

@@ hw/rtl/sha1_hasher.sv @@
// Channel   Dir  Payload                              Transfer
// in_i      in   data_word, byte_count, last          valid && ready
// out_o     out  digest_h0 .. digest_h4               valid && ready
//
// An item that does not complete a 16-word block leaves the hasher ready, unless it is the last.
// A completed block adds 80 rounds at one per cycle and one chain add.
// A last item adds padding words (3 to 18) and one or two blocks.
// Reset clears control state and loads the initial chain value; no clearing pass.
// The digest sits in an output register; a new message is taken while it waits,
// and only the next digest stalls on it.
`include "assert_macros.svh"

module sha1_hasher
  import sha1_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  sha1_in_if.sink       in_i,
  sha1_out_if.source    out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD
  } state_e;

  state_e      state_q, state_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [3:0]  wc_q, wc_d;
  logic [1:0]  pc_q, pc_d;
  word_t       pw_q, pw_d;
  logic [63:0] msg_q, msg_d;
  logic        last_q, last_d;
  logic        pad_first_q, pad_first_d;
  logic        pad_len_q, pad_len_d;
  logic        out_valid_q, out_valid_d;
  word_t       h_q [NUM_H];
  word_t       h_d [NUM_H];
  word_t       wk_q [NUM_H];
  word_t       wk_d [NUM_H];
  word_t       dig_q [NUM_H];
  word_t       dig_d [NUM_H];

  sched_ctrl_t ctrl;
  word_t       fill_word;
  word_t       w_head;

  logic [2:0]  n_bytes;
  logic [2:0]  total;
  logic [63:0] comb_bytes;
  logic [63:0] bit_len;
  word_t       tmp;
  word_t       h_sum [NUM_H];
  logic        emit;

  sha1_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .fill_i (fill_word),
    .head_o (w_head)
  );

  assign n_bytes = (in_i.byte_count > MAX_BYTES) ? MAX_BYTES : in_i.byte_count;
  assign total   = {1'b0, pc_q} + n_bytes;
  assign comb_bytes = {pw_q, 32'h0}
                    | ({in_i.data_word & byte_mask(n_bytes), 32'h0} >> {pc_q, 3'b000});
  assign bit_len = {msg_q[60:0], 3'b000};

  assign tmp = {wk_q[0][26:0], wk_q[0][31:27]}
             + round_f(rnd_q, wk_q[1], wk_q[2], wk_q[3])
             + wk_q[4] + w_head + round_k(rnd_q);

  for (genvar j = 0; j < NUM_H; j++) begin : g_sum
    assign h_sum[j] = h_q[j] + wk_q[j];
  end

  assign emit = last_q && !pad_first_q && pad_len_q;

  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    wc_d        = wc_q;
    pc_d        = pc_q;
    pw_d        = pw_q;
    msg_d       = msg_q;
    last_d      = last_q;
    pad_first_d = pad_first_q;
    pad_len_d   = pad_len_q;
    out_valid_d = out_valid_q;
    h_d         = h_q;
    wk_d        = wk_q;
    dig_d       = dig_q;
    ctrl        = '0;
    fill_word   = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          msg_d       = msg_q + 64'(n_bytes);
          last_d      = in_i.last;
          pad_first_d = 1'b1;
          pad_len_d   = 1'b0;
          pc_d        = total[1:0];
          if (total[2]) begin
            ctrl.shift = 1'b1;
            fill_word  = comb_bytes[63:32];
            pw_d       = comb_bytes[31:0];
            wc_d       = wc_q + 4'd1;
          end else begin
            pw_d = comb_bytes[63:32];
          end
          if (total[2] && wc_q == LAST_POS) begin
            rnd_d   = '0;
            state_d = ST_ROUND;
          end else if (in_i.last) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctrl.shift = 1'b1;
        wc_d       = wc_q + 4'd1;
        if (pad_first_q) begin
          fill_word   = pw_q | (PAD_MARK >> {pc_q, 3'b000});
          pad_len_d   = (wc_q < LEN_HI_POS);
          pad_first_d = 1'b0;
          pc_d        = '0;
          pw_d        = '0;
        end else if (pad_len_q && wc_q == LEN_HI_POS) begin
          fill_word = bit_len[63:32];
        end else if (pad_len_q && wc_q == LAST_POS) begin
          fill_word = bit_len[31:0];
        end
        if (wc_q == LAST_POS) begin
          rnd_d   = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        ctrl.shift = 1'b1;
        ctrl.feed  = 1'b1;
        wk_d[0]    = tmp;
        wk_d[1]    = wk_q[0];
        wk_d[2]    = {wk_q[1][1:0], wk_q[1][31:2]};
        wk_d[3]    = wk_q[2];
        wk_d[4]    = wk_q[3];
        rnd_d      = rnd_q + 7'd1;
        if (rnd_q == LAST_ROUND) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        if (emit) begin
          // hold until the previous digest has been taken
          if (!(out_valid_q && !out_o.ready)) begin
            dig_d       = h_sum;
            out_valid_d = 1'b1;
            h_d         = INIT_H;
            wk_d        = INIT_H;
            msg_d       = '0;
            wc_d        = '0;
            pc_d        = '0;
            pw_d        = '0;
            last_d      = 1'b0;
            state_d     = ST_IDLE;
          end
        end else begin
          h_d  = h_sum;
          wk_d = h_sum;
          if (last_q) begin
            pad_len_d = 1'b1;
            state_d   = ST_PAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      wc_q        <= '0;
      pc_q        <= '0;
      pw_q        <= '0;
      msg_q       <= '0;
      last_q      <= 1'b0;
      pad_first_q <= 1'b0;
      pad_len_q   <= 1'b0;
      out_valid_q <= 1'b0;
      h_q         <= INIT_H;
      wk_q        <= INIT_H;
      dig_q       <= '{default: '0};
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      wc_q        <= wc_d;
      pc_q        <= pc_d;
      pw_q        <= pw_d;
      msg_q       <= msg_d;
      last_q      <= last_d;
      pad_first_q <= pad_first_d;
      pad_len_q   <= pad_len_d;
      out_valid_q <= out_valid_d;
      h_q         <= h_d;
      wk_q        <= wk_d;
      dig_q       <= dig_d;
    end
  end

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.digest_h0 = dig_q[0];
  assign out_o.digest_h1 = dig_q[1];
  assign out_o.digest_h2 = dig_q[2];
  assign out_o.digest_h3 = dig_q[3];
  assign out_o.digest_h4 = dig_q[4];

  `ASSERT_CLK(a_pos_tracks_count, clk_i, rst_ni,
    (state_q == ST_IDLE) |-> ({wc_q, pc_q} == msg_q[5:0]),
    "block position out of step with byte count")
  `ASSERT_CLK(a_round_to_add, clk_i, rst_ni,
    (state_q == ST_ROUND && rnd_q == LAST_ROUND) |=> (state_q == ST_ADD),
    "round sequence did not end in chain add")
  `ASSERT_NEVER(a_digest_from_add, clk_i, rst_ni,
    $rose(out_valid_q) && ($past(state_q) != ST_ADD),
    "digest raised outside chain add")

endmodule
